// File: src/shh_pkg.sv
// ----------------------------------------------------------------------------
// shh_pkg - shared types for the heavy-hitter summary
// Item records passed from the input queue to the heap engine, and result records.
// ----------------------------------------------------------------------------
package shh_pkg;

	localparam int KeyW   = 32;
	localparam int WeightW = 32;
	localparam int CountW = 64;

	typedef struct packed {
		logic [WeightW-1:0] weight;
		logic [KeyW-1:0]    key;
	} item_t;

	typedef struct packed {
		logic [KeyW-1:0]   evicted_key;
		logic              evicted_valid;
		logic              was_inserted;
		logic [CountW-1:0] key_error;
		logic [CountW-1:0] key_count;
	} result_t;

endpackage

// File: src/shh_queue.sv
// ----------------------------------------------------------------------------
// shh_queue - two-entry input item queue
// Decouples the stream input from the heap engine.
// ----------------------------------------------------------------------------
module shh_queue import shh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	item_t       mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	logic        pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: src/shh_heap.sv
// ----------------------------------------------------------------------------
// shh_heap - counter heap engine
// Match, update the slot, sink it one level a cycle, then register the result.
// ----------------------------------------------------------------------------
module shh_heap import shh_pkg::*; #(
	parameter int SLOTS = 31
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  item_t   in_item,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	localparam int IW = $clog2(SLOTS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_UPD  = 2'd1;
	localparam logic [1:0] S_SINK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]        state_q;
	item_t             item_q;
	logic [IW-1:0]     pos_q;
	result_t           pend_q;
	result_t           res_q;
	logic              res_valid_q;

	logic [KeyW-1:0]   key_q   [1:SLOTS];
	logic [CountW-1:0] count_q [1:SLOTS];
	logic [CountW-1:0] error_q [1:SLOTS];
	logic              valid_q [1:SLOTS];

	logic [IW-1:0]     hit;
	logic              hit_any;
	logic [CountW:0]   sum;
	logic [CountW-1:0] sat;
	logic [CountW-1:0] src_count;
	logic [IW:0]       left;
	logic [IW:0]       right;
	logic              has_kids;
	logic [IW-1:0]     pick;

	// Lowest matching valid slot wins
	always_comb begin
		hit     = '0;
		hit_any = 1'b0;
		for (int i = SLOTS; i >= 1; i--) begin
			if (valid_q[i] && key_q[i] == item_q.key) begin
				hit     = IW'(i);
				hit_any = 1'b1;
			end
		end
	end

	assign src_count = hit_any ? count_q[hit] : count_q[1];
	assign sum       = {1'b0, src_count} + {{(CountW+1-WeightW){1'b0}}, item_q.weight};
	assign sat       = sum[CountW] ? {CountW{1'b1}} : sum[CountW-1:0];

	assign left     = {pos_q, 1'b0};
	assign right    = {pos_q, 1'b1};
	assign has_kids = (right <= (IW+1)'(SLOTS));
	assign pick     = (count_q[left[IW-1:0]] < count_q[right[IW-1:0]]) ?
	                  left[IW-1:0] : right[IW-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) item_q <= in_item;
		if (state_q == S_DONE && (!res_valid_q || res_ready)) res_q <= pend_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 1; i <= SLOTS; i++) begin
				key_q[i]   <= '0;
				count_q[i] <= '0;
				error_q[i] <= '0;
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (res_valid_q && res_ready && state_q != S_DONE) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_UPD;
				end
				S_UPD: begin
					if (hit_any) begin
						count_q[hit]         <= sat;
						pend_q.key_count     <= sat;
						pend_q.key_error     <= error_q[hit];
						pend_q.was_inserted  <= 1'b0;
						pend_q.evicted_valid <= 1'b0;
						pend_q.evicted_key   <= '0;
						pos_q                <= hit;
					end else begin
						pend_q.was_inserted <= 1'b1;
						if (!valid_q[1]) begin
							count_q[1]           <= CountW'(item_q.weight);
							pend_q.key_count     <= CountW'(item_q.weight);
							pend_q.key_error     <= error_q[1];
							pend_q.evicted_valid <= 1'b0;
							pend_q.evicted_key   <= '0;
						end else begin
							error_q[1]           <= count_q[1];
							count_q[1]           <= sat;
							pend_q.key_count     <= sat;
							pend_q.key_error     <= count_q[1];
							pend_q.evicted_valid <= 1'b1;
							pend_q.evicted_key   <= key_q[1];
						end
						key_q[1]   <= item_q.key;
						valid_q[1] <= 1'b1;
						pos_q      <= IW'(1);
					end
					state_q <= S_SINK;
				end
				S_SINK: begin
					// swap with the smaller child while the parent is strictly greater
					if (has_kids && count_q[pos_q] > count_q[pick]) begin
						key_q[pos_q]   <= key_q[pick];
						count_q[pos_q] <= count_q[pick];
						error_q[pos_q] <= error_q[pick];
						valid_q[pos_q] <= valid_q[pick];
						key_q[pick]    <= key_q[pos_q];
						count_q[pick]  <= count_q[pos_q];
						error_q[pick]  <= error_q[pos_q];
						valid_q[pick]  <= valid_q[pos_q];
						pos_q          <= pick;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SINK |-> (pos_q >= IW'(1) && pos_q <= IW'(SLOTS)))
		else $error("sink position out of range");

	a_root_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD && !hit_any |=> valid_q[1])
		else $error("root not valid after insertion");

	a_evict_ins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.evicted_valid |-> res_q.was_inserted)
		else $error("eviction without insertion");

endmodule

// File: src/space_saving_heavy_hitters.sv
// ----------------------------------------------------------------------------
// space_saving_heavy_hitters - Space-Saving top-k summary on a min-heap
// Stream in key/weight items, stream out one count report per item.
// ----------------------------------------------------------------------------
// For each item the engine takes it from the queue (IDLE), matches and updates
// the slot (UPD), sinks it down the heap one level at a time (SINK, at most
// floor(log2(SLOTS)) levels, four for 31 slots) until it settles, and hands
// over the result (DONE); only then does it take the next item. The sink-down
// loop over the single heap register file bounds how fast items go through;
// the engine works on one item at a time. A two-entry queue in front
// and a result register behind let both stream sides stall freely.
// Reset empties the table; no clearing pass is needed.
// ----------------------------------------------------------------------------
module space_saving_heavy_hitters import shh_pkg::*; #(
	parameter int SLOTS = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // key[31:0], weight[63:32]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [159:0] m_axis_tdata,  // key_count, key_error, evicted_key
	output logic [1:0]   m_axis_tuser   // was_inserted[0], evicted_valid[1]
);

	item_t   in_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_ready;
	result_t res;

	assign in_item.key    = s_axis_tdata[31:0];
	assign in_item.weight = s_axis_tdata[63:32];

	// Front: hold incoming items until the engine is free
	shh_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	// Back: match, update, sink and report
	shh_heap #(.SLOTS(SLOTS)) u_heap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {res.evicted_key, res.key_error, res.key_count};
	assign m_axis_tuser = {res.evicted_valid, res.was_inserted};

endmodule

// File: tb/sv/space_saving_heavy_hitters_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// space_saving_heavy_hitters_checker - count report scoreboard
// Watches both stream sides, keeps its own min-heap of counters, predicts the
// report for every accepted item and compares it with what the block returns.
// ----------------------------------------------------------------------------
module space_saving_heavy_hitters_checker import shh_pkg::*; #(
	parameter int SLOTS = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [159:0] m_axis_tdata,
	input  logic [1:0]   m_axis_tuser,
	output int           fail_count,
	output int           pending
);

	logic [31:0] heap_key [1:SLOTS];
	logic [63:0] heap_cnt [1:SLOTS];
	logic [63:0] heap_err [1:SLOTS];
	logic        heap_vld [1:SLOTS];
	result_t     report_q [$];

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'd0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	task automatic swap_slots(int a, int b);
		logic [31:0] k;
		logic [63:0] c, e;
		logic        v;
		k = heap_key[a]; c = heap_cnt[a]; e = heap_err[a]; v = heap_vld[a];
		heap_key[a] = heap_key[b]; heap_cnt[a] = heap_cnt[b];
		heap_err[a] = heap_err[b]; heap_vld[a] = heap_vld[b];
		heap_key[b] = k; heap_cnt[b] = c; heap_err[b] = e; heap_vld[b] = v;
	endtask

	task automatic sink_slot(int pos);
		int m;
		while (2 * pos + 1 <= SLOTS) begin
			// ties go to the right child
			m = (heap_cnt[2*pos] < heap_cnt[2*pos+1]) ? 2 * pos : 2 * pos + 1;
			if (heap_cnt[pos] > heap_cnt[m]) begin
				swap_slots(pos, m);
				pos = m;
			end else
				break;
		end
	endtask

	task automatic count_item(logic [31:0] key, logic [31:0] weight);
		result_t r;
		int hit;
		hit = 0;
		r = '0;
		for (int i = 1; i <= SLOTS; i++)
			if (hit == 0 && heap_vld[i] && heap_key[i] == key)
				hit = i;
		if (hit != 0) begin
			heap_cnt[hit] = add_sat(heap_cnt[hit], weight);
			r.key_count = heap_cnt[hit];
			r.key_error = heap_err[hit];
			sink_slot(hit);
		end else begin
			r.was_inserted = 1'b1;
			if (!heap_vld[1])
				heap_cnt[1] = {32'd0, weight};
			else begin
				r.evicted_valid = 1'b1;
				r.evicted_key = heap_key[1];
				heap_err[1] = heap_cnt[1];
				heap_cnt[1] = add_sat(heap_cnt[1], weight);
			end
			heap_key[1] = key;
			heap_vld[1] = 1'b1;
			r.key_count = heap_cnt[1];
			r.key_error = heap_err[1];
			sink_slot(1);
		end
		report_q.push_back(r);
	endtask

	assign pending = report_q.size();

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		logic [31:0] got_ev;
		logic [63:0] got_cnt, got_err;
		if (!arst_n) begin
			for (int i = 1; i <= SLOTS; i++) begin
				heap_key[i] = '0; heap_cnt[i] = '0; heap_err[i] = '0; heap_vld[i] = 1'b0;
			end
			report_q.delete();
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_cnt = m_axis_tdata[63:0];
				got_err = m_axis_tdata[127:64];
				got_ev  = m_axis_tdata[159:128];
				if (report_q.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected report count=%0h", got_cnt);
					fail_count <= fail_count + 1;
				end else begin
					e = report_q.pop_front();
					if (got_cnt !== e.key_count || got_err !== e.key_error ||
							m_axis_tuser[0] !== e.was_inserted ||
							m_axis_tuser[1] !== e.evicted_valid || got_ev !== e.evicted_key) begin
						if (fail_count < 10) begin
							$display("ERROR: exp cnt=%0h err=%0h ins=%0b ev=%0b/%0h",
								e.key_count, e.key_error, e.was_inserted,
								e.evicted_valid, e.evicted_key);
							$display("       got cnt=%0h err=%0h ins=%0b ev=%0b/%0h",
								got_cnt, got_err, m_axis_tuser[0],
								m_axis_tuser[1], got_ev);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			// predict after the compare so a same-edge report never meets its own entry
			if (s_axis_tvalid && s_axis_tready)
				count_item(s_axis_tdata[31:0], s_axis_tdata[63:32]);
		end
	end

endmodule

// File: tb/sv/space_saving_heavy_hitters_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// space_saving_heavy_hitters_tb - stimulus for the heavy-hitter summary
// Drives key/weight items with random gaps and back-pressure; the checker
// predicts every report and counts mismatches.
// ----------------------------------------------------------------------------
module space_saving_heavy_hitters_tb;
	localparam int SLOTS = 31;
	localparam int CYCLE_LIMIT = 200000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;   // key[31:0], weight[63:32]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [159:0] m_axis_tdata;   // key_count, key_error, evicted_key
	logic [1:0]   m_axis_tuser;   // was_inserted, evicted_valid
	int           fail_count;
	int           pending;
	int           cycles;
	bit           calm;           // no idling on either side

	space_saving_heavy_hitters #(.SLOTS(SLOTS)) dut (.*);

	space_saving_heavy_hitters_checker #(.SLOTS(SLOTS)) checker_i (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// receiver holds tready low with a chance of about 36 in a hundred, except while calm
	always @(posedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 36);

	// offer one item, holding it until it is taken; valid stays high into the
	// next item unless an idle gap is drawn
	task automatic send_item(logic [31:0] key, logic [31:0] weight);
		if (!calm && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (!calm && $urandom_range(99) < 36)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {weight, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// hot keys come back often; cold ones churn the root
	function automatic logic [31:0] pick_key();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(15);
			4, 5, 6:    return 32'h1000 + $urandom_range(40);
			7:          return $urandom_range(15) | 32'hFFFF_FFF0;
			default:    return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(9))
			0:       return 0;
			1:       return $urandom;
			2:       return 32'hFFFF_FFFF;
			default: return $urandom_range(20);
		endcase
	endfunction

	initial begin
		cycles = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty root, zero key with zero weight, extremes
		send_item(32'h0, 32'h0);
		send_item(32'h0, 32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(32'hAAAA_5555, 32'h5555_AAAA);
		send_item(32'h5555_AAAA, 32'hAAAA_5555);
		// fill the table so later new keys evict
		for (int i = 0; i < 30; i++)
			send_item(32'h100 + i, i + 1);
		// evictions with ties at the root
		send_item(32'hDEAD_0001, 32'h1);
		send_item(32'hDEAD_0002, 32'h0);
		// push one key towards saturation
		for (int i = 0; i < 6; i++)
			send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		s_axis_tvalid <= 1'b0;

		// hold off until all reports are back
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		for (int n = 0; n < 1650; n++) begin
			calm = (n >= 600 && n < 800);
			send_item(pick_key(), pick_weight());
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: files.f
src/shh_pkg.sv
src/shh_queue.sv
src/shh_heap.sv
src/space_saving_heavy_hitters.sv
tb/sv/space_saving_heavy_hitters_checker.sv
tb/sv/space_saving_heavy_hitters_tb.sv
